>>> rtl/bmpr_pkg.sv
// Shared constants, types and phase codes of the BMP stream decoder.
package bmpr_pkg;

  // Largest accepted width or height and the palette length of 8-bit images
  localparam int MAX_DIM       = 4096;
  localparam int PALETTE_BYTES = 1024;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ROWB_W = $clog2(MAX_DIM * 4 + 1);
  localparam int IMG_W  = ROWB_W + DIM_W;
  localparam int IDX_W  = 24;
  localparam int HOFF_W = 6;

  localparam int HDR_BYTES    = 54;
  localparam int DATA_START_8 = HDR_BYTES + PALETTE_BYTES;
  localparam int SIZE_SLACK   = 4;

  localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
  localparam logic [7:0]  INFO_HDR_SIZE = 8'd40;
  localparam logic [7:0]  OPAQUE        = 8'hFF;
  localparam logic [15:0] DEPTH_8       = 16'd8;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [15:0] DEPTH_32      = 16'd32;

  // Header byte offsets
  localparam int OFF_MAGIC_LO = 0;
  localparam int OFF_MAGIC_HI = 1;
  localparam int OFF_FSIZE    = 2;
  localparam int OFF_INFO     = 14;
  localparam int OFF_WIDTH    = 18;
  localparam int OFF_HEIGHT   = 22;
  localparam int OFF_DEPTH    = 28;
  localparam int OFF_COMPR    = 30;
  localparam int OFF_IMGSIZE  = 34;

  // Result FIFO
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PALETTE = 3'd1,
    PH_PIXELS  = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef struct packed {
    logic             item_kind;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [1:0]       decode_status;
    logic             final_flag;
  } result_t;

endpackage

>>> rtl/bmpr_if.sv
// Handshake channels for file bytes in and decoded results out.
interface bmpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, file_byte, end_of_file, input ready);
  modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

interface bmpr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [bmpr_pkg::IDX_W-1:0] pixel_index;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic [7:0]                alpha;
  logic [1:0]                decode_status;
  logic                      final_flag;

  modport source (output valid, item_kind, pixel_index, red, green, blue, alpha,
                  decode_status, final_flag, input ready);
  modport sink (input valid, item_kind, pixel_index, red, green, blue, alpha,
                decode_status, final_flag, output ready);
endinterface

>>> rtl/bmp_stream_to_rgba_core.sv
// Top level of the BMP stream decoder: header parse, pixel walk and result queue.
//
//   channel   dir  payload                                       per transaction
//   bytes     in   file_byte, end_of_file                        one file byte
//   results   out  item_kind, pixel_index, red, green, blue,     one pixel or the
//                  alpha, decode_status, final_flag              final status
//
// One byte is taken per cycle while bytes.ready is high; its results are written to a
// four-entry queue at the same edge and can leave on the next cycle. The byte with
// end_of_file set gives the status result, after the last pixel when it completes one.
// bytes.ready stays high while the queue holds at least two free entries; a stalled sink
// fills it and ready drops. Synchronous reset returns to the header phase.
module bmp_stream_to_rgba_core (
  input  logic       clk,
  input  logic       rst,
  bmpr_in_if.sink    bytes,
  bmpr_out_if.source results
);

  localparam int DW = bmpr_pkg::DIM_W;
  localparam int RW = bmpr_pkg::ROWB_W;
  localparam int PW = 2 * bmpr_pkg::DIM_W;

  // Parse state
  logic [31:0]      byte_count, byte_count_next;
  logic [31:0]      file_size, file_size_next;
  logic [31:0]      image_bytes, image_bytes_next;
  logic [31:0]      width, width_next;
  logic [31:0]      height, height_next;
  logic [15:0]      depth, depth_next;
  bmpr_pkg::phase_t phase, phase_next;
  logic [23:0]      pixel_bytes, pixel_bytes_next;
  logic [1:0]       pix_k, pix_k_next;
  logic [DW-1:0]    column_count, column_count_next;
  logic [DW-1:0]    row_count, row_count_next;
  logic [RW-1:0]    row_byte_count, row_byte_count_next;
  logic [1:0]       error_code, error_code_next;

  // Geometry worked out from the header fields, updated every cycle
  logic [1:0]                   bpp_m1, bpp_m1_next;
  logic [RW-1:0]                raw_len, raw_len_next;
  logic [RW-1:0]                row_len, row_len_next;
  logic [bmpr_pkg::IMG_W-1:0]   img_total;
  logic [32:0]                  data_end;

  logic                         acc, eof, room;
  logic [7:0]                   b;
  logic [bmpr_pkg::HOFF_W-1:0]  off6;
  logic                         hdr_last, unsup_byte, empty_img, size_bad;
  logic [32:0]                  size_lo, size_hi;
  logic [DW-1:0]                width_t, height_t, rc1, drow;
  logic [RW-1:0]                rbc1;
  logic                         in_raw, pix_out, row_end, last_row;
  logic [PW-1:0]                idx_full;
  logic [1:0]                   status_val;
  bmpr_pkg::result_t            pix_res, st_res, wr_a;
  logic [1:0]                   push_count;

  assign acc      = bytes.valid & bytes.ready;
  assign b        = bytes.file_byte;
  assign eof      = bytes.end_of_file;
  assign bytes.ready = room;

  assign off6     = byte_count[bmpr_pkg::HOFF_W-1:0];
  assign hdr_last = off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::HDR_BYTES - 1);
  assign width_t  = width[DW-1:0];
  assign height_t = height[DW-1:0];
  assign empty_img = (width == '0) || (height == '0);

  // Geometry
  always_comb begin
    case (depth)
      bmpr_pkg::DEPTH_8: begin
        bpp_m1_next  = 2'd0;
        raw_len_next = RW'(width_t);
      end
      bmpr_pkg::DEPTH_24: begin
        bpp_m1_next  = 2'd2;
        raw_len_next = (RW'(width_t) << 1) + RW'(width_t);
      end
      default: begin
        bpp_m1_next  = 2'd3;
        raw_len_next = RW'(width_t) << 2;
      end
    endcase
    if (depth == bmpr_pkg::DEPTH_24) begin
      row_len_next = (raw_len + RW'(3)) & ~RW'(3);
    end else begin
      row_len_next = raw_len;
    end
  end

  always_ff @(posedge clk) begin
    bpp_m1    <= bpp_m1_next;
    raw_len   <= raw_len_next;
    row_len   <= row_len_next;
    img_total <= bmpr_pkg::IMG_W'(row_len) * bmpr_pkg::IMG_W'(height_t);
    data_end  <= {1'b0, image_bytes} + ((depth == bmpr_pkg::DEPTH_8)
                 ? 33'(bmpr_pkg::DATA_START_8) : 33'(bmpr_pkg::HDR_BYTES));
  end

  assign size_lo  = 33'(img_total) + 33'(bmpr_pkg::HDR_BYTES);
  assign size_hi  = size_lo + 33'(bmpr_pkg::SIZE_SLACK);
  assign size_bad = ({1'b0, file_size} < size_lo) || ({1'b0, file_size} > size_hi);

  assign unsup_byte =
      ((off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_INFO)) && (b != bmpr_pkg::INFO_HDR_SIZE))
   || ((off6 > bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_INFO))
       && (off6 < bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_WIDTH)) && (b != 8'd0))
   || ((off6 >= bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_COMPR))
       && (off6 < bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_IMGSIZE)) && (b != 8'd0));

  // Pixel walk
  assign in_raw   = row_byte_count < raw_len;
  assign pix_out  = (phase == bmpr_pkg::PH_PIXELS) && in_raw && (pix_k == bpp_m1);
  assign rbc1     = row_byte_count + 1'b1;
  assign row_end  = rbc1 >= row_len;
  assign rc1      = row_count + 1'b1;
  assign last_row = rc1 >= height_t;
  assign drow     = (depth == bmpr_pkg::DEPTH_24) ? (height_t - 1'b1 - row_count) : row_count;
  assign idx_full = PW'(drow) * PW'(width_t) + PW'(column_count);

  // Next values of the datapath
  always_comb begin
    byte_count_next     = (byte_count == '1) ? byte_count : byte_count + 1'b1;
    file_size_next      = file_size;
    image_bytes_next    = image_bytes;
    width_next          = width;
    height_next         = height;
    depth_next          = depth;
    error_code_next     = error_code;
    pixel_bytes_next    = pixel_bytes;
    pix_k_next          = pix_k;
    column_count_next   = column_count;
    row_count_next      = row_count;
    row_byte_count_next = row_byte_count;

    case (phase)
      bmpr_pkg::PH_HEADER: begin
        if ((off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_MAGIC_LO)) && (b != bmpr_pkg::BMP_MAGIC[7:0]))
          error_code_next = bmpr_pkg::ST_INVALID;
        if ((off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_MAGIC_HI)) && (b != bmpr_pkg::BMP_MAGIC[15:8]))
          error_code_next = bmpr_pkg::ST_INVALID;
        if (unsup_byte && (error_code == bmpr_pkg::ST_OK))
          error_code_next = bmpr_pkg::ST_UNSUPPORTED;
        for (int i = 0; i < 4; i++) begin
          if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_FSIZE + i))   file_size_next[8*i +: 8] = b;
          if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_WIDTH + i))   width_next[8*i +: 8] = b;
          if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_HEIGHT + i))  height_next[8*i +: 8] = b;
          if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_IMGSIZE + i)) image_bytes_next[8*i +: 8] = b;
        end
        if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_DEPTH))     depth_next[7:0]  = b;
        if (off6 == bmpr_pkg::HOFF_W'(bmpr_pkg::OFF_DEPTH + 1)) depth_next[15:8] = b;
        if (hdr_last) begin
          if (((depth != bmpr_pkg::DEPTH_8) && (depth != bmpr_pkg::DEPTH_24)
               && (depth != bmpr_pkg::DEPTH_32))
              || (width > 32'(bmpr_pkg::MAX_DIM)) || (height > 32'(bmpr_pkg::MAX_DIM))) begin
            if (error_code == bmpr_pkg::ST_OK) error_code_next = bmpr_pkg::ST_UNSUPPORTED;
          end
          if ((error_code_next == bmpr_pkg::ST_OK) && (depth == bmpr_pkg::DEPTH_24) && size_bad)
            error_code_next = bmpr_pkg::ST_INVALID;
        end
      end
      bmpr_pkg::PH_PIXELS: begin
        if (in_raw) begin
          if (pix_k == bpp_m1) begin
            pixel_bytes_next  = '0;
            pix_k_next        = '0;
            column_count_next = column_count + 1'b1;
          end else begin
            pixel_bytes_next[8*pix_k +: 8] = b;
            pix_k_next = pix_k + 1'b1;
          end
        end
        row_byte_count_next = rbc1;
        if (row_end) begin
          row_byte_count_next = '0;
          column_count_next   = '0;
          pixel_bytes_next    = '0;
          pix_k_next          = '0;
          row_count_next      = rc1;
        end
      end
      default: begin
      end
    endcase
  end

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    case (phase)
      bmpr_pkg::PH_HEADER: begin
        if (hdr_last) begin
          if (error_code_next != bmpr_pkg::ST_OK)
            phase_next = bmpr_pkg::PH_ERROR;
          else if ((depth == bmpr_pkg::DEPTH_8) && (bmpr_pkg::PALETTE_BYTES > 0))
            phase_next = bmpr_pkg::PH_PALETTE;
          else
            phase_next = empty_img ? bmpr_pkg::PH_DONE : bmpr_pkg::PH_PIXELS;
        end
      end
      bmpr_pkg::PH_PALETTE: begin
        if (byte_count_next >= 32'(bmpr_pkg::DATA_START_8))
          phase_next = empty_img ? bmpr_pkg::PH_DONE : bmpr_pkg::PH_PIXELS;
      end
      bmpr_pkg::PH_PIXELS: begin
        if (row_end && last_row) phase_next = bmpr_pkg::PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // Results of the current byte
  always_comb begin
    case (phase_next)
      bmpr_pkg::PH_HEADER: status_val = bmpr_pkg::ST_INVALID;
      bmpr_pkg::PH_ERROR:  status_val = error_code_next;
      bmpr_pkg::PH_DONE:   status_val = ({1'b0, byte_count_next} < data_end)
                                        ? bmpr_pkg::ST_INVALID : bmpr_pkg::ST_OK;
      default:             status_val = bmpr_pkg::ST_INVALID;
    endcase

    pix_res               = '0;
    pix_res.item_kind     = bmpr_pkg::KIND_PIXEL;
    pix_res.pixel_index   = bmpr_pkg::IDX_W'(idx_full);
    pix_res.decode_status = bmpr_pkg::ST_OK;
    pix_res.final_flag    = 1'b0;
    case (bpp_m1)
      2'd0: begin
        pix_res.red   = b;
        pix_res.green = b;
        pix_res.blue  = b;
        pix_res.alpha = bmpr_pkg::OPAQUE;
      end
      2'd2: begin
        pix_res.red   = b;
        pix_res.green = pixel_bytes[15:8];
        pix_res.blue  = pixel_bytes[7:0];
        pix_res.alpha = bmpr_pkg::OPAQUE;
      end
      default: begin
        pix_res.red   = pixel_bytes[7:0];
        pix_res.green = pixel_bytes[15:8];
        pix_res.blue  = pixel_bytes[23:16];
        pix_res.alpha = b;
      end
    endcase

    st_res               = '0;
    st_res.item_kind     = bmpr_pkg::KIND_STATUS;
    st_res.decode_status = status_val;
    st_res.final_flag    = 1'b1;

    wr_a       = pix_out ? pix_res : st_res;
    push_count = acc ? ({1'b0, pix_out} + {1'b0, eof}) : 2'd0;
  end

  // Parse state; an end-of-file transaction starts the next file afresh
  always_ff @(posedge clk) begin
    if (rst || (acc && eof)) begin
      byte_count     <= '0;
      file_size      <= '0;
      image_bytes    <= '0;
      width          <= '0;
      height         <= '0;
      depth          <= '0;
      phase          <= bmpr_pkg::PH_HEADER;
      pixel_bytes    <= '0;
      pix_k          <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      error_code     <= bmpr_pkg::ST_OK;
    end else if (acc) begin
      byte_count     <= byte_count_next;
      file_size      <= file_size_next;
      image_bytes    <= image_bytes_next;
      width          <= width_next;
      height         <= height_next;
      depth          <= depth_next;
      phase          <= phase_next;
      pixel_bytes    <= pixel_bytes_next;
      pix_k          <= pix_k_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
      error_code     <= error_code_next;
    end
  end

  bmpr_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .wr_a       (wr_a),
    .wr_b       (st_res),
    .room       (room),
    .results    (results)
  );

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && eof) |=> (byte_count == '0) && (phase == bmpr_pkg::PH_HEADER))
    else $error("decoder did not restart after end of file");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (phase == bmpr_pkg::PH_PIXELS) |-> (row_count < height_t) && (pix_k <= bpp_m1))
    else $error("pixel walk out of range");

  a_two_results: assert property (@(posedge clk) disable iff (rst)
    (acc && eof && pix_out) |=> results.valid)
    else $error("results of a final byte not queued");

endmodule

>>> rtl/bmpr_res_fifo.sv
// Small result FIFO that takes up to two results per cycle and hands out one while results.ready is high.
module bmpr_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  bmpr_pkg::result_t wr_a,
  input  bmpr_pkg::result_t wr_b,
  output logic              room,
  bmpr_out_if.source        results
);

  bmpr_pkg::result_t mem [bmpr_pkg::FIFO_DEPTH];

  logic [bmpr_pkg::FIFO_AW-1:0] wptr, rptr;
  logic [bmpr_pkg::FIFO_CW-1:0] count, count_next;
  logic                         pop;
  logic [bmpr_pkg::FIFO_AW-1:0] wptr_b;

  assign pop    = results.valid & results.ready;
  assign wptr_b = wptr + 1'b1;
  assign room   = count <= bmpr_pkg::FIFO_CW'(bmpr_pkg::FIFO_DEPTH - 2);

  assign count_next = count + bmpr_pkg::FIFO_CW'(push_count)
                      - bmpr_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + bmpr_pkg::FIFO_AW'(push_count);
      rptr  <= rptr + bmpr_pkg::FIFO_AW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wptr] <= wr_a;
    end
    if (push_count == 2'd2) begin
      mem[wptr_b] <= wr_b;
    end
  end

  assign results.valid         = count != '0;
  assign results.item_kind     = mem[rptr].item_kind;
  assign results.pixel_index   = mem[rptr].pixel_index;
  assign results.red           = mem[rptr].red;
  assign results.green         = mem[rptr].green;
  assign results.blue          = mem[rptr].blue;
  assign results.alpha         = mem[rptr].alpha;
  assign results.decode_status = mem[rptr].decode_status;
  assign results.final_flag    = mem[rptr].final_flag;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the BMP stream decoder: byte stimulus, result prediction and checks.
module tb_top;
  import bmpr_pkg::*;

  localparam int RANDOM_ITEMS     = 1850;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 16;
  localparam int CYCLE_LIMIT      = 900_000;

  typedef enum int {IMG_EXACT, IMG_ZERO, IMG_OVERSIZED} img_field_e;

  logic clk;
  logic rst;

  bmpr_in_if  byte_ch ();
  bmpr_out_if result_ch ();

  bmp_stream_to_rgba_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  int failures      = 0;
  int bytes_sent    = 0;
  int files_sent    = 0;
  int results_seen  = 0;
  int decoded_bytes = 0;
  int hold_requests = 0;
  int cycle_count   = 0;
  bit sender_idling = 1'b1;
  bit sink_idling   = 1'b1;

  logic [7:0] file_buf[$];
  result_t    awaited_results[$];

  // Decoder state as the stream has left it
  logic [31:0] byte_cnt, file_size, image_bytes, img_w, img_h;
  logic [31:0] col, row, row_pos;
  logic [15:0] depth;
  logic [23:0] pix_acc;
  logic [1:0]  pend_status;
  phase_t      phase;

  function automatic logic [31:0] px_bytes();
    return (depth == DEPTH_8) ? 32'd1 : ((depth == DEPTH_24) ? 32'd3 : 32'd4);
  endfunction

  function automatic logic [31:0] stride_now();
    logic [31:0] raw;
    raw = img_w * px_bytes();
    return (depth == DEPTH_24) ? ((raw + 32'd3) & ~32'd3) : raw;
  endfunction

  function automatic logic [31:0] origin_now();
    return HDR_BYTES + ((depth == DEPTH_8) ? PALETTE_BYTES : 0);
  endfunction

  function automatic void start_file();
    byte_cnt = '0; file_size = '0; image_bytes = '0; img_w = '0; img_h = '0;
    col = '0; row = '0; row_pos = '0; depth = '0; pix_acc = '0;
    pend_status = ST_OK;
    phase = PH_HEADER;
  endfunction

  function automatic void mark_unsupported();
    if (pend_status == ST_OK) pend_status = ST_UNSUPPORTED;
  endfunction

  function automatic void open_pixels();
    phase = (img_w == 0 || img_h == 0) ? PH_DONE : PH_PIXELS;
  endfunction

  function automatic void take_header_byte(input logic [31:0] off, input logic [7:0] b);
    longint slack;
    if (off == OFF_MAGIC_LO && b != BMP_MAGIC[7:0]) pend_status = ST_INVALID;
    if (off == OFF_MAGIC_HI && b != BMP_MAGIC[15:8]) pend_status = ST_INVALID;
    if (off >= OFF_FSIZE && off < OFF_FSIZE + 4)
      file_size |= 32'(b) << ((off - OFF_FSIZE) * 8);
    if (off == OFF_INFO && b != INFO_HDR_SIZE) mark_unsupported();
    if (off > OFF_INFO && off < OFF_INFO + 4 && b != 8'd0) mark_unsupported();
    if (off >= OFF_WIDTH && off < OFF_WIDTH + 4)
      img_w |= 32'(b) << ((off - OFF_WIDTH) * 8);
    if (off >= OFF_HEIGHT && off < OFF_HEIGHT + 4)
      img_h |= 32'(b) << ((off - OFF_HEIGHT) * 8);
    if (off >= OFF_DEPTH && off < OFF_DEPTH + 2)
      depth |= 16'(b) << ((off - OFF_DEPTH) * 8);
    if (off >= OFF_COMPR && off < OFF_COMPR + 4 && b != 8'd0) mark_unsupported();
    if (off >= OFF_IMGSIZE && off < OFF_IMGSIZE + 4)
      image_bytes |= 32'(b) << ((off - OFF_IMGSIZE) * 8);

    if (off == HDR_BYTES - 1) begin
      if (depth != DEPTH_8 && depth != DEPTH_24 && depth != DEPTH_32) mark_unsupported();
      if (img_w > MAX_DIM || img_h > MAX_DIM) mark_unsupported();
      if (pend_status == ST_OK && depth == DEPTH_24) begin
        slack = longint'({32'd0, file_size})
              - longint'({32'd0, stride_now()}) * longint'({32'd0, img_h})
              - longint'(HDR_BYTES);
        if (slack < 0 || slack > SIZE_SLACK) pend_status = ST_INVALID;
      end
      if (pend_status != ST_OK) phase = PH_ERROR;
      else if (depth == DEPTH_8 && PALETTE_BYTES > 0) phase = PH_PALETTE;
      else open_pixels();
    end
  endfunction

  function automatic void take_pixel_byte(input logic [7:0] b);
    logic [31:0] bpp, k, drow;
    result_t     px;
    bpp = px_bytes();
    if (row_pos < img_w * bpp) begin
      k = row_pos - col * bpp;
      if (k + 1 < bpp) begin
        pix_acc = pix_acc | (24'(b) << (8 * k));
      end else begin
        // 24-bit rows are stored bottom-up
        drow = (depth == DEPTH_24) ? img_h - 1 - row : row;
        px = '0;
        px.item_kind   = KIND_PIXEL;
        px.pixel_index = 24'(drow * img_w + col);
        if (bpp == 1) begin
          px.red = b; px.green = b; px.blue = b; px.alpha = OPAQUE;
        end else if (bpp == 3) begin
          px.red = b; px.green = pix_acc[15:8]; px.blue = pix_acc[7:0]; px.alpha = OPAQUE;
        end else begin
          px.red = pix_acc[7:0]; px.green = pix_acc[15:8]; px.blue = pix_acc[23:16];
          px.alpha = b;
        end
        awaited_results.push_back(px);
        pix_acc = '0;
        col++;
      end
    end
    row_pos++;
    if (row_pos >= stride_now()) begin
      row_pos = '0; col = '0; pix_acc = '0;
      row++;
      if (row >= img_h) phase = PH_DONE;
    end
  endfunction

  function automatic logic [1:0] closing_status();
    if (phase == PH_HEADER) return ST_INVALID;
    if (phase == PH_ERROR) return pend_status;
    if (phase != PH_DONE) return ST_INVALID;
    if ({32'd0, byte_cnt} < 64'(origin_now()) + {32'd0, image_bytes}) return ST_INVALID;
    return ST_OK;
  endfunction

  function automatic void decode_file_byte(input logic [7:0] b, input logic eof);
    logic [31:0] off;
    result_t     st;
    off = byte_cnt;
    if (byte_cnt != '1) byte_cnt++;
    if (phase == PH_HEADER || phase == PH_PIXELS) decoded_bytes++;
    case (phase)
      PH_HEADER:  take_header_byte(off, b);
      PH_PALETTE: if (byte_cnt >= origin_now()) open_pixels();
      PH_PIXELS:  take_pixel_byte(b);
      default: ;
    endcase
    if (eof) begin
      st = '0;
      st.item_kind     = KIND_STATUS;
      st.decode_status = closing_status();
      st.final_flag    = 1'b1;
      awaited_results.push_back(st);
      start_file();
    end
  endfunction

  // File image construction

  function automatic int image_stride(input logic [15:0] depth_f, input int w);
    if (depth_f == DEPTH_24) return (w * 3 + 3) & ~3;
    if (depth_f == DEPTH_8) return w;
    return w * 4;
  endfunction

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void append_random(input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
  endfunction

  function automatic void build_header(input logic [15:0] magic, input logic [31:0] fsize,
                                       input logic [31:0] info, input logic [31:0] w,
                                       input logic [31:0] h, input logic [15:0] depth_f,
                                       input logic [31:0] compr, input logic [31:0] img_field);
    file_buf.delete();
    push_le(magic, 2);
    push_le(fsize, 4);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le(info, 4);
    push_le(w, 4);
    push_le(h, 4);
    push_le(32'd1, 2);
    push_le(depth_f, 2);
    push_le(compr, 4);
    push_le(img_field, 4);
    append_random(16);
  endfunction

  function automatic void build_image(input logic [15:0] depth_f, input int w, input int h,
                                      input int slack, input img_field_e img_mode,
                                      input int trailing);
    int          img, origin;
    logic [31:0] img_field;
    img    = image_stride(depth_f, w) * h;
    origin = HDR_BYTES + ((depth_f == DEPTH_8) ? PALETTE_BYTES : 0);
    case (img_mode)
      IMG_EXACT: img_field = img;
      IMG_ZERO:  img_field = '0;
      default:   img_field = img + $urandom_range(8, 1);
    endcase
    build_header(BMP_MAGIC, 32'(origin + img + slack), INFO_HDR_SIZE, w, h, depth_f, '0,
                 img_field);
    if (depth_f == DEPTH_8) append_random(PALETTE_BYTES);
    append_random(img + trailing);
  endfunction

  // Driving and checking

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (sender_idling && $urandom_range(99) < 13) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.file_byte   <= b;
    byte_ch.end_of_file <= eof;
    do @(posedge clk); while (!byte_ch.ready);
    decode_file_byte(b, eof);
    bytes_sent++;
  endtask

  // Send the first count bytes of the image (all of it for zero or less, or past its size), end of file on the last
  task automatic send_file(input int count);
    int n;
    n = (count <= 0 || count > file_buf.size()) ? file_buf.size() : count;
    for (int i = 0; i < n; i++) send_byte(file_buf[i], i == n - 1);
    files_sent++;
  endtask

  task automatic send_bare_header(input logic [15:0] magic, input logic [31:0] fsize,
                                  input logic [31:0] info, input logic [31:0] w,
                                  input logic [31:0] h, input logic [15:0] depth_f,
                                  input logic [31:0] compr, input int body_len);
    build_header(magic, fsize, info, w, h, depth_f, compr, '0);
    append_random(body_len);
    send_file(0);
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  initial begin : result_checker
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result transaction with none awaited: kind %0d index %0d",
                 result_ch.item_kind, result_ch.pixel_index);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          check_field("item_kind", want.item_kind, result_ch.item_kind);
          check_field("pixel_index", want.pixel_index, result_ch.pixel_index);
          check_field("red", want.red, result_ch.red);
          check_field("green", want.green, result_ch.green);
          check_field("blue", want.blue, result_ch.blue);
          check_field("alpha", want.alpha, result_ch.alpha);
          check_field("decode_status", want.decode_status, result_ch.decode_status);
          check_field("final_flag", want.final_flag, result_ch.final_flag);
        end
      end
    end
  end

  // Result sink pacing; a hold request stalls it for a fixed stretch
  initial begin : sink_pacing
    int served, hold_left;
    served    = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(sink_idling && $urandom_range(99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Tests

  task automatic test_header_checks();
    // a lone byte that also ends the file
    file_buf.delete();
    append_random(1);
    send_file(0);
    build_image(DEPTH_32, 2, 2, 0, IMG_EXACT, 0);
    send_file(30);
    build_image(DEPTH_32, 1, 1, 0, IMG_EXACT, 0);
    file_buf[OFF_MAGIC_LO] = BMP_MAGIC[7:0] ^ 8'h01;
    send_file(0);
    // bad magic outranks the unsupported info header
    send_bare_header(BMP_MAGIC ^ 16'h0100, '0, 32'd12, 2, 2, DEPTH_32, '0, 16);
    send_bare_header(BMP_MAGIC, '0, 32'd41, 2, 2, DEPTH_32, '0, 16);
    send_bare_header(BMP_MAGIC, '0, 32'h0001_0028, 2, 2, DEPTH_32, '0, 16);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, 2, 2, DEPTH_32, 32'd1, 16);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, 2, 2, DEPTH_32, 32'h8000_0000, 16);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, 2, 2, 16'd16, '0, 16);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, 2, 2, DEPTH_24 | 16'h0100, '0, 16);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, MAX_DIM + 1, 1, DEPTH_32, '0, 8);
    send_bare_header(BMP_MAGIC, '0, INFO_HDR_SIZE, 1, 32'hFFFF_FFFE, DEPTH_32, '0, 8);
    // 24-bit file size one short of the image, then one past the slack
    send_bare_header(BMP_MAGIC, HDR_BYTES + 15, INFO_HDR_SIZE, 2, 2, DEPTH_24, '0, 16);
    send_bare_header(BMP_MAGIC, HDR_BYTES + 16 + SIZE_SLACK + 1, INFO_HDR_SIZE, 2, 2,
                     DEPTH_24, '0, 16);
    build_image(DEPTH_32, 0, 3, 0, IMG_EXACT, 0);
    send_file(0);
    build_image(DEPTH_24, 3, 0, 2, IMG_OVERSIZED, 0);
    send_file(0);
    wait_drained();
  endtask

  task automatic test_pixel_formats();
    build_image(DEPTH_32, 3, 2, 0, IMG_EXACT, 3);
    send_file(0);
    build_image(DEPTH_24, 3, 3, SIZE_SLACK, IMG_EXACT, 0);
    send_file(0);
    build_image(DEPTH_24, 4, 1, 0, IMG_ZERO, 2);
    send_file(0);
    build_image(DEPTH_8, 5, 2, 7, IMG_ZERO, 0);
    send_file(0);
    build_image(DEPTH_32, 2, 2, 0, IMG_OVERSIZED, 0);
    send_file(0);
    build_image(DEPTH_24, 5, 4, 1, IMG_EXACT, 0);
    send_file(HDR_BYTES + 30);
    build_image(DEPTH_8, 2, 2, 0, IMG_EXACT, 0);
    send_file(500);
    build_image(DEPTH_8, 1, MAX_DIM, 0, IMG_EXACT, 0);
    send_file(0);
    build_image(DEPTH_24, MAX_DIM, 1, 0, IMG_EXACT, 0);
    send_file(0);
    // largest frames, cut short: top rows of a flipped image reach the highest indexes
    send_bare_header(BMP_MAGIC, HDR_BYTES + MAX_DIM * MAX_DIM * 3, INFO_HDR_SIZE,
                     MAX_DIM, MAX_DIM, DEPTH_24, '0, 9);
    send_bare_header(BMP_MAGIC, $urandom, INFO_HDR_SIZE, MAX_DIM, MAX_DIM, DEPTH_32, '0, 16);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    hold_requests++;
    build_image(DEPTH_32, 8, 8, 0, IMG_EXACT, 0);
    send_file(0);
    build_image(DEPTH_24, 3, 2, 0, IMG_EXACT, 0);
    send_file(0);
    wait_drained();
  endtask

  task automatic test_random_files();
    int         pick, w, h, file_no, start;
    logic [15:0] depth_f;
    img_field_e img_mode;
    file_no = 0;
    start   = decoded_bytes;
    while (decoded_bytes - start < RANDOM_ITEMS) begin
      // a run of files with both sides at full rate
      sender_idling = !(file_no >= 4 && file_no < 10);
      sink_idling   = sender_idling;
      pick    = $urandom_range(99);
      depth_f = ($urandom_range(99) < 15) ? DEPTH_8 : ($urandom_range(1) ? DEPTH_24 : DEPTH_32);
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6);
      h = $urandom_range(5);
      if ($urandom_range(9) == 0) img_mode = IMG_OVERSIZED;
      else img_mode = $urandom_range(1) ? IMG_ZERO : IMG_EXACT;
      build_image(depth_f, w, h, $urandom_range(SIZE_SLACK), img_mode,
                  ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0);
      if (pick < 70) begin
        send_file(0);
      end else if (pick < 80) begin
        send_file($urandom_range(file_buf.size(), 1));
      end else if (pick < 92) begin
        file_buf[$urandom_range(OFF_IMGSIZE + 3)] = 8'($urandom);
        send_file(0);
      end else begin
        file_buf.delete();
        append_random($urandom_range(60, 1));
        send_file(0);
      end
      if ($urandom_range(19) == 0) hold_requests++;
      if ($urandom_range(11) == 0) wait_drained();
      file_no++;
    end
    sender_idling = 1'b1;
    sink_idling   = 1'b1;
  endtask

  initial begin
    rst                 <= 1'b1;
    byte_ch.valid       <= 1'b0;
    byte_ch.file_byte   <= '0;
    byte_ch.end_of_file <= 1'b0;
    start_file();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_header_checks();
    test_pixel_formats();
    test_back_pressure();
    test_random_files();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      failures++;
    end
    $display("Covered header checks, truncation, 8/24/32-bit pixels and sink stalls:");
    $display("  %0d files, %0d bytes sent, %0d results checked, %0d failures",
             files_sent, bytes_sent, results_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bmpr_pkg.sv
rtl/bmpr_if.sv
rtl/bmpr_res_fifo.sv
rtl/bmp_stream_to_rgba_core.sv
tb/tb_top.sv
